>>> hdl/vra_pkg.sv
// Shared constants and types for the vision rotary angle generator.
`timescale 1ns / 1ps
package vra_pkg;

    localparam int FREQ_SLOTS_DEF = 16;
    localparam int MAX_GRID_DEF   = 1024;
    localparam int FREQ_FRAC_DEF  = 23;

    localparam int FREQ_W     = 24;
    localparam int ANGLE_W    = 33;
    localparam int SLOT_W     = 4;
    localparam int CFG_DIM_W  = 11;
    localparam int MERGE_W    = 4;
    localparam int FRAME_W    = 10;
    localparam int INNER_W    = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_DIM_W-1:0] MAX_FRAMES = 11'd1024;
    localparam logic [MERGE_W-1:0]   MAX_MERGE  = 4'd8;

    localparam logic [CFG_DIM_W-1:0] GRID_T_RST = 11'd1;
    localparam logic [CFG_DIM_W-1:0] GRID_H_RST = 11'd2;
    localparam logic [CFG_DIM_W-1:0] GRID_W_RST = 11'd2;
    localparam logic [MERGE_W-1:0]   MERGE_RST  = 4'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_T = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_H = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_W = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE  = 8'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TOKEN = 1'b1;

    typedef struct packed {
        logic start;
        logic last_grid;
    } vra_ctl_t;

endpackage

>>> hdl/vra_angle_pipe.sv
// Frequency table and shared multiplier that stream one token's angle beats.
`timescale 1ns / 1ps
module vra_angle_pipe #(
    parameter int FREQ_SLOTS = vra_pkg::FREQ_SLOTS_DEF,
    parameter int POS_W      = 10,
    localparam int IDX_W     = (FREQ_SLOTS > 1) ? $clog2(FREQ_SLOTS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [vra_pkg::FREQ_W-1:0]   wr_data,
    input  vra_pkg::vra_ctl_t            ctl,
    input  logic [POS_W-1:0]             hpos,
    input  logic [POS_W-1:0]             wpos,
    output logic                         busy,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [vra_pkg::ANGLE_W-1:0]  m_angle,
    output logic                         m_is_width_half,
    output logic [vra_pkg::SLOT_W-1:0]   m_freq_slot,
    output logic                         m_last_in_row,
    output logic                         m_last_of_grid
);
    import vra_pkg::*;

    localparam int NBEAT  = 2 * FREQ_SLOTS;
    localparam int CNT_W  = $clog2(NBEAT + 1);
    localparam int PROD_W = POS_W + FREQ_W;
    localparam int SAT_W  = (PROD_W > ANGLE_W) ? PROD_W : ANGLE_W + 1;
    localparam logic [CNT_W-1:0]   LAST_CNT  = CNT_W'(NBEAT - 1);
    localparam logic [CNT_W-1:0]   HALF_CNT  = CNT_W'(FREQ_SLOTS);
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;

    logic [FREQ_W-1:0] freq_mem [FREQ_SLOTS];

    logic             issuing_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [POS_W-1:0] hpos_reg, wpos_reg;
    logic             lgrid_reg;

    logic              a_valid_reg;
    logic [FREQ_W-1:0] a_inv_reg;
    logic [POS_W-1:0]  a_pos_reg;
    logic              a_half_reg;
    logic [IDX_W-1:0]  a_slot_reg;
    logic              a_lrow_reg;

    logic               m_valid_reg;
    logic [ANGLE_W-1:0] m_angle_reg;
    logic               m_half_reg;
    logic [SLOT_W-1:0]  m_slot_reg;
    logic               m_lrow_reg;
    logic               m_lgrid_reg;

    logic                    adv;
    logic                    issue_half;
    logic [CNT_W-1:0]        issue_slot;
    logic [IDX_W-1:0]        issue_addr;
    logic [PROD_W-1:0]       prod;
    logic [SAT_W-1:0]        prod_ext;
    logic                    prod_sat;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    // The output register frees up when empty or when its beat is taken.
    assign adv        = !m_valid_reg || m_ready;
    assign issue_half = cnt_reg >= HALF_CNT;
    assign issue_slot = issue_half ? cnt_reg - HALF_CNT : cnt_reg;
    assign issue_addr = issue_slot[IDX_W-1:0];

    assign prod     = a_pos_reg * a_inv_reg;
    assign prod_ext = SAT_W'(prod);
    assign prod_sat = prod_ext > SAT_W'(ANGLE_MAX);
    assign slot_ext = {{SLOT_W{1'b0}}, a_slot_reg};

    assign busy            = issuing_reg || a_valid_reg;
    assign m_valid         = m_valid_reg;
    assign m_angle         = m_angle_reg;
    assign m_is_width_half = m_half_reg;
    assign m_freq_slot     = m_slot_reg;
    assign m_last_in_row   = m_lrow_reg;
    assign m_last_of_grid  = m_lgrid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            freq_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg <= 1'b0;
            cnt_reg     <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                m_valid_reg <= a_valid_reg;
            end
            if (ctl.start) begin
                issuing_reg <= 1'b1;
                cnt_reg     <= '0;
            end else if (adv) begin
                a_valid_reg <= issuing_reg;
                if (issuing_reg) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == LAST_CNT) begin
                        issuing_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            hpos_reg  <= hpos;
            wpos_reg  <= wpos;
            lgrid_reg <= ctl.last_grid;
        end
        if (adv && issuing_reg && !ctl.start) begin
            a_inv_reg  <= freq_mem[issue_addr];
            a_pos_reg  <= issue_half ? wpos_reg : hpos_reg;
            a_half_reg <= issue_half;
            a_slot_reg <= issue_addr;
            a_lrow_reg <= cnt_reg == LAST_CNT;
        end
        if (adv && a_valid_reg) begin
            m_angle_reg <= prod_sat ? ANGLE_MAX : prod_ext[ANGLE_W-1:0];
            m_half_reg  <= a_half_reg;
            m_slot_reg  <= slot_ext[SLOT_W-1:0];
            m_lrow_reg  <= a_lrow_reg;
            m_lgrid_reg <= lgrid_reg;
        end
    end

endmodule

>>> hdl/vision_rope_angle_generator.sv
// Top level: configuration, merge-block position counters and token sequencer.
// Load beat: taken and written to the frequency table, no result; ready again the next cycle.
// Token beat (dropped on an empty grid): check and setup states, then 2*FREQ_SLOTS angle
// beats at one per cycle while the result side does not stall, from the single shared
// multiplier; the next token is accepted only once the angle pipe is no longer busy.
// Reset clears the position counters and restores the default geometry registers;
// the frequency table is not cleared and must be loaded before use.
`timescale 1ns / 1ps
module vision_rope_angle_generator #(
    parameter int FREQ_SLOTS     = vra_pkg::FREQ_SLOTS_DEF,
    parameter int MAX_GRID       = vra_pkg::MAX_GRID_DEF,
    parameter int FREQ_FRAC_BITS = vra_pkg::FREQ_FRAC_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vra_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [3:0]                      s_freq_index,
    input  logic [vra_pkg::FREQ_W-1:0]      s_freq_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [vra_pkg::ANGLE_W-1:0]     m_angle,
    output logic                            m_is_width_half,
    output logic [vra_pkg::SLOT_W-1:0]      m_freq_slot,
    output logic                            m_last_in_row,
    output logic                            m_last_of_grid
);
    import vra_pkg::*;

    localparam int IDX_W  = (FREQ_SLOTS > 1) ? $clog2(FREQ_SLOTS) : 1;
    localparam int BLK_W  = $clog2(MAX_GRID);
    localparam int DIM_W  = ($clog2(MAX_GRID + 1) > CFG_DIM_W) ? $clog2(MAX_GRID + 1)
                                                                : CFG_DIM_W;
    localparam int CMP_W  = ((DIM_W > BLK_W + 4) ? DIM_W : BLK_W + 4) + 2;
    localparam logic [5:0]  HALF_LIM = 6'(FREQ_SLOTS);
    localparam logic [31:0] FREQ_ONE = 32'd1 << FREQ_FRAC_BITS;

    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SETUP, S_RUN} state_t;

    state_t               state_reg;
    logic [CFG_DIM_W-1:0] grid_t_reg, grid_h_reg, grid_w_reg;
    logic [MERGE_W-1:0]   merge_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [BLK_W-1:0]     block_row_reg, block_col_reg;
    logic [INNER_W-1:0]   inner_row_reg, inner_col_reg;

    logic [CFG_DIM_W-1:0] t_c;
    logic [DIM_W-1:0]     gh_ext, gw_ext, h_c, w_c;
    logic [MERGE_W-1:0]   m_c;
    logic [CMP_W-1:0]     h_w, w_w, m_w, br_m, bc_m, hpos_w, wpos_w;
    logic                 empty, bad, row_end, col_end;
    logic                 ir_wrap, ic_wrap, fc_wrap, last_tok;

    logic                 take;
    logic                 wr_en;
    logic [IDX_W+3:0]     addr_ext;
    logic                 freq_big;
    logic [FREQ_W-1:0]    wr_data;
    vra_ctl_t             ctl;
    logic                 busy;

    assign cfg_ready = 1'b1;
    assign s_ready   = state_reg == S_IDLE;
    assign take      = s_valid && s_ready;

    assign wr_en    = take && (s_opcode == OP_LOAD) && ({2'b00, s_freq_index} < HALF_LIM);
    assign addr_ext = {{IDX_W{1'b0}}, s_freq_index};
    assign freq_big = {8'd0, s_freq_value} > FREQ_ONE;
    assign wr_data  = freq_big ? FREQ_ONE[FREQ_W-1:0] : s_freq_value;

    // Clamp the geometry registers to the supported range.
    assign t_c    = (grid_t_reg > MAX_FRAMES) ? MAX_FRAMES : grid_t_reg;
    assign gh_ext = DIM_W'(grid_h_reg);
    assign gw_ext = DIM_W'(grid_w_reg);
    assign h_c    = (gh_ext > DIM_W'(MAX_GRID)) ? DIM_W'(MAX_GRID) : gh_ext;
    assign w_c    = (gw_ext > DIM_W'(MAX_GRID)) ? DIM_W'(MAX_GRID) : gw_ext;
    assign m_c    = (merge_reg > MAX_MERGE) ? MAX_MERGE : merge_reg;
    assign h_w    = CMP_W'(h_c);
    assign w_w    = CMP_W'(w_c);
    assign m_w    = CMP_W'(m_c);

    // Block index b is in range when (b+1)*m fits in the dimension.
    assign br_m   = CMP_W'(block_row_reg) * m_w;
    assign bc_m   = CMP_W'(block_col_reg) * m_w;
    assign empty  = (t_c == '0) || (m_c == '0) || (m_w > h_w) || (m_w > w_w);
    assign bad    = ({1'b0, frame_reg} >= t_c) || (br_m + m_w > h_w) || (bc_m + m_w > w_w)
                 || ({1'b0, inner_row_reg} >= m_c) || ({1'b0, inner_col_reg} >= m_c);

    assign hpos_w  = br_m + CMP_W'(inner_row_reg);
    assign wpos_w  = bc_m + CMP_W'(inner_col_reg);
    assign row_end = br_m + (m_w << 1) > h_w;
    assign col_end = bc_m + (m_w << 1) > w_w;
    assign ir_wrap = {1'b0, inner_row_reg} + 4'd1 >= m_c;
    assign ic_wrap = {1'b0, inner_col_reg} + 4'd1 >= m_c;
    assign fc_wrap = {1'b0, frame_reg} + 11'd1 >= t_c;
    assign last_tok = fc_wrap && row_end && col_end && ir_wrap && ic_wrap;

    assign ctl.start     = state_reg == S_SETUP;
    assign ctl.last_grid = last_tok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_t_reg <= GRID_T_RST;
            grid_h_reg <= GRID_H_RST;
            grid_w_reg <= GRID_W_RST;
            merge_reg  <= MERGE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GRID_T: grid_t_reg <= cfg_data[CFG_DIM_W-1:0];
                CFG_GRID_H: grid_h_reg <= cfg_data[CFG_DIM_W-1:0];
                CFG_GRID_W: grid_w_reg <= cfg_data[CFG_DIM_W-1:0];
                CFG_MERGE:  merge_reg  <= cfg_data[MERGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            frame_reg     <= '0;
            block_row_reg <= '0;
            block_col_reg <= '0;
            inner_row_reg <= '0;
            inner_col_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (take && s_opcode == OP_TOKEN) begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // Drop the beat on an empty grid; restart counters left out of range.
                    if (empty) begin
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_SETUP;
                        if (bad) begin
                            frame_reg     <= '0;
                            block_row_reg <= '0;
                            block_col_reg <= '0;
                            inner_row_reg <= '0;
                            inner_col_reg <= '0;
                        end
                    end
                end
                S_SETUP: begin
                    state_reg <= S_RUN;
                    if (!ic_wrap) begin
                        inner_col_reg <= inner_col_reg + INNER_W'(1);
                    end else begin
                        inner_col_reg <= '0;
                        if (!ir_wrap) begin
                            inner_row_reg <= inner_row_reg + INNER_W'(1);
                        end else begin
                            inner_row_reg <= '0;
                            if (!col_end) begin
                                block_col_reg <= block_col_reg + BLK_W'(1);
                            end else begin
                                block_col_reg <= '0;
                                if (!row_end) begin
                                    block_row_reg <= block_row_reg + BLK_W'(1);
                                end else begin
                                    block_row_reg <= '0;
                                    frame_reg     <= fc_wrap ? '0 : frame_reg + FRAME_W'(1);
                                end
                            end
                        end
                    end
                end
                S_RUN: begin
                    if (!busy) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    vra_angle_pipe #(
        .FREQ_SLOTS (FREQ_SLOTS),
        .POS_W      (BLK_W)
    ) u_pipe (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .wr_en           (wr_en),
        .wr_addr         (addr_ext[IDX_W-1:0]),
        .wr_data         (wr_data),
        .ctl             (ctl),
        .hpos            (hpos_w[BLK_W-1:0]),
        .wpos            (wpos_w[BLK_W-1:0]),
        .busy            (busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_angle         (m_angle),
        .m_is_width_half (m_is_width_half),
        .m_freq_slot     (m_freq_slot),
        .m_last_in_row   (m_last_in_row),
        .m_last_of_grid  (m_last_of_grid)
    );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the vision rotary angle generator: directed and random beats.
`timescale 1ns / 1ps
module tb_top;
    import vra_pkg::*;

    localparam int FREQ_SLOTS   = FREQ_SLOTS_DEF;
    localparam int SETTLE       = 2 * FREQ_SLOTS + 8;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int N_DIRECTED   = 23;

    localparam logic [FREQ_W-1:0]    ONE_Q     = 24'h800000;
    localparam logic [ANGLE_W-1:0]   ANGLE_MAX = 33'h1FFFFFFFF;
    localparam logic [ANGLE_W-1:0]   POS_ONE   = 33'h000800000;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE  = 8'hFF;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic               op;
        logic [3:0]         idx;
        logic [FREQ_W-1:0]  val;
        logic               has_ref;
        logic [ANGLE_W-1:0] ref_angle;
        logic               ref_last;
    } stim_row_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               width_half;
        logic [SLOT_W-1:0]  slot;
        logic               last_row;
        logic               last_grid;
    } angle_beat_t;

    // Reset geometry is 1 x 2 x 2 with merge 2: four tokens, then wrap.
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{OP_LOAD,  4'd0,  24'h800000, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd1,  24'hFFFFFF, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd2,  24'h000000, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd3,  24'h800001, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd4,  24'h7FFFFF, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd5,  24'h000001, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd6,  24'h555555, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd7,  24'hAAAAAA, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd8,  24'h123456, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd9,  24'h400000, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd10, 24'h000100, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd11, 24'h7F0F0F, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd12, 24'h0ABCDE, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd13, 24'h3C3C3C, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd14, 24'h654321, 1'b0, 33'd0,   1'b0},
        '{OP_LOAD,  4'd15, 24'h800000, 1'b0, 33'd0,   1'b0},
        '{OP_TOKEN, 4'd0,  24'h000000, 1'b1, 33'd0,   1'b0},
        '{OP_TOKEN, 4'd0,  24'h000000, 1'b1, 33'd0,   1'b0},
        '{OP_TOKEN, 4'd0,  24'h000000, 1'b1, POS_ONE, 1'b0},
        '{OP_TOKEN, 4'd0,  24'h000000, 1'b1, POS_ONE, 1'b1},
        '{OP_TOKEN, 4'd0,  24'h000000, 1'b1, 33'd0,   1'b0},
        '{OP_LOAD,  4'd9,  24'h000000, 1'b0, 33'd0,   1'b0},
        '{OP_TOKEN, 4'd15, 24'hFFFFFF, 1'b0, 33'd0,   1'b0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_opcode;
    logic [3:0]            s_freq_index;
    logic [FREQ_W-1:0]     s_freq_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [ANGLE_W-1:0]    m_angle;
    logic                  m_is_width_half;
    logic [SLOT_W-1:0]     m_freq_slot;
    logic                  m_last_in_row;
    logic                  m_last_of_grid;

    // Shadow of the block: frequency table, geometry and position counters.
    logic [FREQ_W-1:0]    inv_tab [FREQ_SLOTS];
    logic [CFG_DIM_W-1:0] grid_t, grid_h, grid_w;
    logic [MERGE_W-1:0]   merge_sz;
    logic [FRAME_W-1:0]   frame_q, brow_q, bcol_q;
    logic [INNER_W-1:0]   irow_q, icol_q;

    angle_beat_t exp_angles [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;

    vision_rope_angle_generator i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_freq_index    (s_freq_index),
        .s_freq_value    (s_freq_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_angle         (m_angle),
        .m_is_width_half (m_is_width_half),
        .m_freq_slot     (m_freq_slot),
        .m_last_in_row   (m_last_in_row),
        .m_last_of_grid  (m_last_of_grid)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct  = 84;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct = 84;
            end
            default: begin
                send_idle_pct  = 38;
                recv_stall_pct = 38;
            end
        endcase
    endtask

    // Work out the angle beats one accepted input beat causes and queue them.
    task automatic predict_item(input stim_row_t row);
        int unsigned       t_eff, h_eff, w_eff, m_eff, n_bh, n_bw, h_pos, w_pos, pos;
        longint unsigned   prod;
        logic              grid_end;
        angle_beat_t       beat;
        int                j;
        if (row.op == OP_LOAD) begin
            // 4-bit index covers exactly the table depth
            inv_tab[row.idx] = (row.val > ONE_Q) ? ONE_Q : row.val;
            return;
        end
        t_eff = 32'((grid_t > MAX_FRAMES) ? MAX_FRAMES : grid_t);
        h_eff = (grid_h > MAX_GRID_DEF) ? MAX_GRID_DEF : grid_h;
        w_eff = (grid_w > MAX_GRID_DEF) ? MAX_GRID_DEF : grid_w;
        m_eff = 32'((merge_sz > MAX_MERGE) ? MAX_MERGE : merge_sz);
        if (t_eff == 0 || m_eff == 0)
            return;
        n_bh = h_eff / m_eff;
        n_bw = w_eff / m_eff;
        if (n_bh == 0 || n_bw == 0)
            return;
        // a geometry change can leave the walk outside the grid: restart it
        if (frame_q >= t_eff || brow_q >= n_bh || bcol_q >= n_bw ||
            irow_q >= m_eff || icol_q >= m_eff) begin
            frame_q = '0;
            brow_q  = '0;
            bcol_q  = '0;
            irow_q  = '0;
            icol_q  = '0;
        end
        h_pos = brow_q * m_eff + irow_q;
        w_pos = bcol_q * m_eff + icol_q;
        grid_end = (frame_q == t_eff - 1) && (brow_q == n_bh - 1) && (bcol_q == n_bw - 1) &&
                   (irow_q == m_eff - 1) && (icol_q == m_eff - 1);
        for (j = 0; j < 2 * FREQ_SLOTS; j++) begin
            beat.width_half = (j >= FREQ_SLOTS);
            beat.slot       = SLOT_W'(beat.width_half ? j - FREQ_SLOTS : j);
            pos             = beat.width_half ? w_pos : h_pos;
            prod            = longint'(pos) * longint'(inv_tab[beat.slot]);
            beat.angle      = (prod > ANGLE_MAX) ? ANGLE_MAX : prod[ANGLE_W-1:0];
            beat.last_row   = (j == 2 * FREQ_SLOTS - 1);
            beat.last_grid  = grid_end;
            if (row.has_ref) begin
                if (j == 0)
                    beat.angle = row.ref_angle;
                beat.last_grid = row.ref_last;
            end
            exp_angles.insert(exp_angles.size(), beat);
        end
        // advance in merge-block order: in-block column first, frame last
        if (icol_q + 1 < m_eff) begin
            icol_q++;
        end else begin
            icol_q = '0;
            if (irow_q + 1 < m_eff) begin
                irow_q++;
            end else begin
                irow_q = '0;
                if (bcol_q + 1 < n_bw) begin
                    bcol_q++;
                end else begin
                    bcol_q = '0;
                    if (brow_q + 1 < n_bh) begin
                        brow_q++;
                    end else begin
                        brow_q = '0;
                        frame_q = (frame_q + 1 < t_eff) ? FRAME_W'(frame_q + 1) : '0;
                    end
                end
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input stim_row_t row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= row.op;
        s_freq_index <= row.idx;
        s_freq_value <= row.val;
        do @(posedge aclk); while (!s_ready);
        predict_item(row);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_GRID_T: grid_t   = data[CFG_DIM_W-1:0];
            CFG_GRID_H: grid_h   = data[CFG_DIM_W-1:0];
            CFG_GRID_W: grid_w   = data[CFG_DIM_W-1:0];
            CFG_MERGE:  merge_sz = data[MERGE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_grid(input logic [31:0] t, h, w, m);
        cfg_write(CFG_GRID_T, t);
        cfg_write(CFG_GRID_H, h);
        cfg_write(CFG_GRID_W, w);
        cfg_write(CFG_MERGE, m);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected beat, then let the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (exp_angles.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Random noise above the bits a register keeps.
    function automatic logic [31:0] with_noise(input int unsigned v, input int keep);
        logic [31:0] mask;
        mask = (32'd1 << keep) - 1;
        return ($urandom & ~mask) | (v & mask);
    endfunction

    function automatic stim_row_t random_row(input int token_pct);
        stim_row_t row;
        row.op        = ($urandom_range(99) < token_pct) ? OP_TOKEN : OP_LOAD;
        row.idx       = 4'($urandom_range(15));
        row.has_ref   = 1'b0;
        row.ref_angle = '0;
        row.ref_last  = 1'b0;
        case ($urandom_range(4))
            0: row.val = FREQ_W'($urandom);
            1: row.val = ONE_Q;
            2: row.val = ONE_Q + FREQ_W'(1);
            default: row.val = FREQ_W'($urandom_range(ONE_Q));
        endcase
        return row;
    endfunction

    task automatic send_random(input int n_items, input int token_pct, input bit pause_mid);
        int i;
        for (i = 0; i < n_items; i++) begin
            if (pause_mid && i == n_items / 2) begin
                // hold the input until the block has emptied
                s_valid <= 1'b0;
                do @(negedge aclk); while (exp_angles.size() != 0);
            end
            send_item(random_row(token_pct));
        end
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(input string what, input logic [ANGLE_W-1:0] want,
                                        input logic [ANGLE_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        angle_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_angles.size() == 0) begin
                $display("%0t ns: unexpected angle beat: expected none, got angle %0d slot %0d",
                         $time, m_angle, m_freq_slot);
                mismatches++;
            end else begin
                want = exp_angles.pop_front();
                check_field("angle", want.angle, m_angle);
                check_field("is_width_half", ANGLE_W'(want.width_half),
                            ANGLE_W'(m_is_width_half));
                check_field("freq_slot", ANGLE_W'(want.slot), ANGLE_W'(m_freq_slot));
                check_field("last_in_row", ANGLE_W'(want.last_row), ANGLE_W'(m_last_in_row));
                check_field("last_of_grid", ANGLE_W'(want.last_grid),
                            ANGLE_W'(m_last_of_grid));
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        int i, p;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_opcode     = OP_LOAD;
        s_freq_index = '0;
        s_freq_value = '0;
        m_ready      = 1'b0;
        mismatches   = 0;
        hold_cycles  = 0;
        set_idling(IDLE_NONE);
        grid_t   = GRID_T_RST;
        grid_h   = GRID_H_RST;
        grid_w   = GRID_W_RST;
        merge_sz = MERGE_RST;
        frame_q  = '0;
        brow_q   = '0;
        bcol_q   = '0;
        irow_q   = '0;
        icol_q   = '0;
        for (i = 0; i < FREQ_SLOTS; i++)
            inv_tab[i] = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fill the whole table, then walk the reset geometry through a wrap
        for (i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED[i]);

        // largest legal geometry; a write to an unused index must change nothing
        drain();
        cfg_write(CFG_NONE, $urandom);
        set_grid(32'd1024, 32'd1024, 32'd1024, 32'd8);
        set_idling(IDLE_RECV);
        send_random(12, 75, 1'b0);

        // single-patch grid: every token is the last one
        drain();
        set_grid(32'd1, 32'd1, 32'd1, 32'd1);
        set_idling(IDLE_SEND);
        send_random(10, 75, 1'b0);

        // no frames: tokens are dropped and counters hold
        drain();
        set_grid(with_noise(0, CFG_DIM_W), 32'd4, 32'd6, 32'd2);
        set_idling(IDLE_BOTH);
        send_random(8, 75, 1'b0);

        // all-ones writes saturate frames, height and merge size
        drain();
        set_grid(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd16, 32'hFFFFFFFF);
        set_idling(IDLE_NONE);
        send_random(10, 75, 1'b0);

        // zero merge size: empty grid
        drain();
        set_grid(32'd2, 32'd8, 32'd8, with_noise(0, MERGE_W));
        set_idling(IDLE_SEND);
        send_random(5, 75, 1'b0);

        // height below merge size: empty grid
        drain();
        set_grid(32'd2, 32'd3, 32'd8, 32'd4);
        set_idling(IDLE_BOTH);
        send_random(5, 75, 1'b0);

        // long receiver hold-off while tokens keep coming, so the input backs up
        drain();
        set_grid(32'd2, 32'd4, 32'd4, 32'd2);
        set_idling(IDLE_NONE);
        hold_cycles = 600;
        send_random(10, 100, 1'b0);

        for (p = 0; p < 8; p++) begin
            drain();
            set_grid(with_noise($urandom_range(3, 1), CFG_DIM_W),
                     with_noise($urandom_range(12, 1), CFG_DIM_W),
                     with_noise($urandom_range(12, 1), CFG_DIM_W),
                     with_noise($urandom_range(4, 1), MERGE_W));
            set_idling(idle_mode_t'(p % 4));
            send_random(24, 75, p == 5);
        end

        drain();
        if (mismatches == 0 && exp_angles.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
